@@ sv/swdq_pkg.sv @@
// Shared types and constants for the sorted wake-up delay queue.
// No dependencies; the RTL files that use it refer to it by scoped names, the testbench imports it.
package swdq_pkg;

  // Default number of queue entries.
  localparam int QUEUE_DEPTH = 32;

  // Field widths.
  localparam int TIME_W  = 32;
  localparam int TID_W   = 8;
  localparam int ENTRY_W = TIME_W + TID_W;

  // Request types.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_DELAY = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_TIME   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_WAKE   = 2'd3;

  // Compare unit operating modes.
  localparam logic CMP_INSERT = 1'b0;  // new wake time < stored wake time
  localparam logic CMP_TICK   = 1'b1;  // stored wake time < current time

endpackage

@@ sv/swdq_if.sv @@
// Request and result channel interfaces (valid/ready plus payload).
// Depends on swdq_pkg for field widths.
interface swdq_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [swdq_pkg::TID_W-1:0]   task_id;
  logic [swdq_pkg::TIME_W-1:0]  wake_time;

  modport source (output valid, req_type, task_id, wake_time, input ready);
  modport sink   (input valid, req_type, task_id, wake_time, output ready);
endinterface

interface swdq_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [swdq_pkg::TID_W-1:0]   task_id_res;
  logic [swdq_pkg::TIME_W-1:0]  ticks;
  logic                         last;

  modport source (output valid, kind, task_id_res, ticks, last, input ready);
  modport sink   (input valid, kind, task_id_res, ticks, last, output ready);
endinterface

@@ sv/swdq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered, enabled read data. No dependencies.
module swdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/swdq_cmp.sv @@
// Shared wake-time comparator used by both the insert scan and tick release.
// Depends on swdq_pkg for widths and mode codes.
module swdq_cmp (
  input  logic                        cmp_sel,
  input  logic [swdq_pkg::TIME_W-1:0] rd_wake,
  input  logic [swdq_pkg::TIME_W-1:0] req_wake,
  input  logic [swdq_pkg::TIME_W-1:0] cur_time,
  output logic                        hit
);

  logic [swdq_pkg::TIME_W-1:0] op_a;
  logic [swdq_pkg::TIME_W-1:0] op_b;

  // Operand select: one unsigned less-than serves both uses
  always_comb begin
    unique case (cmp_sel)
      swdq_pkg::CMP_TICK: begin
        op_a = rd_wake;
        op_b = cur_time;
      end
      default: begin
        op_a = req_wake;
        op_b = rd_wake;
      end
    endcase
  end

  assign hit = (op_a < op_b);

endmodule

@@ sv/sorted_wakeup_delay_queue.sv @@
// Sorted wake-up delay queue: tick counter plus a wake-time ordered ring in RAM.
// Requests are taken only in idle: a query or reject goes straight to the reply; a delay shifts up
// each entry that wakes later than the new one; a tick releases every due head entry.
// Reset (rst_n low, synchronous): count, head pointer and tick counter clear;
// queue RAM is not cleared and needs no clearing pass. One request at a time.
module sorted_wakeup_delay_queue #(
  parameter int QUEUE_DEPTH = swdq_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  swdq_in_if.sink     in_ch,
  swdq_out_if.source  out_ch
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TW    = swdq_pkg::TIME_W;
  localparam int IW    = swdq_pkg::TID_W;
  localparam int EW    = swdq_pkg::ENTRY_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RESP    = 3'd1;
  localparam logic [2:0] S_INS_RD  = 3'd2;
  localparam logic [2:0] S_INS_CMP = 3'd3;
  localparam logic [2:0] S_TK_RD   = 3'd4;
  localparam logic [2:0] S_TK_CMP  = 3'd5;
  localparam logic [2:0] S_TK_FIN  = 3'd6;

  // Ring slot of queue position off, relative to head
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  logic [2:0]       state_r, state_nxt;
  logic [TW-1:0]    time_r, time_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [IW-1:0]    req_tid_r, req_tid_nxt;
  logic [TW-1:0]    req_wake_r, req_wake_nxt;
  logic [1:0]       res_kind_r, res_kind_nxt;
  logic [IW-1:0]    res_tid_r, res_tid_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [IW-1:0]    pend_tid_r, pend_tid_nxt;
  logic [TW-1:0]    pend_wake_r, pend_wake_nxt;

  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic [IW-1:0]    out_tid_r;
  logic [TW-1:0]    out_ticks_r;
  logic             out_last_r;

  logic             ld_out;
  logic [1:0]       ld_kind;
  logic [IW-1:0]    ld_tid;
  logic [TW-1:0]    ld_ticks;
  logic             ld_last;
  logic             out_free;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0]    ram_wdata, ram_rdata;
  logic [TW-1:0]    rd_wake;
  logic [IW-1:0]    rd_tid;

  logic             cmp_sel;
  logic             cmp_hit;

  assign rd_wake = ram_rdata[EW-1:IW];
  assign rd_tid  = ram_rdata[IW-1:0];

  // Queue storage
  swdq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared comparator
  assign cmp_sel = (state_r == S_TK_CMP) ? swdq_pkg::CMP_TICK : swdq_pkg::CMP_INSERT;

  swdq_cmp u_cmp (
    .cmp_sel  (cmp_sel),
    .rd_wake  (rd_wake),
    .req_wake (req_wake_r),
    .cur_time (time_r),
    .hit      (cmp_hit)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    time_nxt      = time_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    req_tid_nxt   = req_tid_r;
    req_wake_nxt  = req_wake_r;
    res_kind_nxt  = res_kind_r;
    res_tid_nxt   = res_tid_r;
    pend_v_nxt    = pend_v_r;
    pend_tid_nxt  = pend_tid_r;
    pend_wake_nxt = pend_wake_r;
    ld_out        = 1'b0;
    ld_kind       = swdq_pkg::KIND_WAKE;
    ld_tid        = pend_tid_r;
    ld_ticks      = pend_wake_r;
    ld_last       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = slot_of(head_r, pos_r);
    ram_wdata     = {req_wake_r, req_tid_r};
    ram_raddr     = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.req_type)
            swdq_pkg::REQ_TICK: begin
              time_nxt  = time_r + TW'(1);
              state_nxt = S_TK_RD;
            end
            swdq_pkg::REQ_QUERY: begin
              res_kind_nxt = swdq_pkg::KIND_TIME;
              res_tid_nxt  = '0;
              state_nxt    = S_RESP;
            end
            swdq_pkg::REQ_DELAY: begin
              req_tid_nxt  = in_ch.task_id;
              req_wake_nxt = in_ch.wake_time;
              res_tid_nxt  = in_ch.task_id;
              if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
                res_kind_nxt = swdq_pkg::KIND_REJECT;
                state_nxt    = S_RESP;
              end else begin
                pos_nxt   = cnt_r;
                state_nxt = S_INS_RD;
              end
            end
            default: begin
              // unused request type: dropped
            end
          endcase
        end
      end

      S_RESP: begin
        if (out_free) begin
          ld_out    = 1'b1;
          ld_kind   = res_kind_r;
          ld_tid    = res_tid_r;
          ld_ticks  = time_r;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      // Scan back from the tail, moving later entries up one slot
      S_INS_RD: begin
        if (pos_r == '0) begin
          ram_we       = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
          res_kind_nxt = swdq_pkg::KIND_ACCEPT;
          state_nxt    = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(head_r, pos_r - CNT_W'(1));
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        ram_we = 1'b1;
        if (cmp_hit) begin
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - CNT_W'(1);
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt      = cnt_r + CNT_W'(1);
          res_kind_nxt = swdq_pkg::KIND_ACCEPT;
          state_nxt    = S_RESP;
        end
      end

      // Release due head entries; one held back to learn whether it is last
      S_TK_RD: begin
        if (cnt_r == '0) begin
          state_nxt = pend_v_r ? S_TK_FIN : S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = head_r;
          state_nxt = S_TK_CMP;
        end
      end

      S_TK_CMP: begin
        if (cmp_hit) begin
          if (!pend_v_r || out_free) begin
            ld_out        = pend_v_r;
            pend_v_nxt    = 1'b1;
            pend_tid_nxt  = rd_tid;
            pend_wake_nxt = rd_wake;
            head_nxt      = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : head_r + IDX_W'(1);
            cnt_nxt       = cnt_r - CNT_W'(1);
            state_nxt     = S_TK_RD;
          end
        end else begin
          state_nxt = pend_v_r ? S_TK_FIN : S_IDLE;
        end
      end

      S_TK_FIN: begin
        if (out_free) begin
          ld_out     = 1'b1;
          ld_last    = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      time_r   <= '0;
      head_r   <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      time_r   <= time_nxt;
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    req_tid_r   <= req_tid_nxt;
    req_wake_r  <= req_wake_nxt;
    res_kind_r  <= res_kind_nxt;
    res_tid_r   <= res_tid_nxt;
    pend_tid_r  <= pend_tid_nxt;
    pend_wake_r <= pend_wake_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_kind_r  <= ld_kind;
      out_tid_r   <= ld_tid;
      out_ticks_r <= ld_ticks;
      out_last_r  <= ld_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.task_id_res = out_tid_r;
  assign out_ch.ticks       = out_ticks_r;
  assign out_ch.last        = out_last_r;

endmodule

@@ sv/swdq_checker.sv @@
// Port-level checks for the sorted wake-up delay queue, bound to the top.
// Depends on swdq_pkg and sorted_wakeup_delay_queue.
module swdq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  in_req_type,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_kind,
  input logic [swdq_pkg::TID_W-1:0]  out_task_id_res,
  input logic [swdq_pkg::TIME_W-1:0] out_ticks,
  input logic                        out_last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_task_id_res) && $stable(out_ticks) && $stable(out_last))
    else $error("result changed while stalled");

  // Only wake results may be followed by more results of the same request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != swdq_pkg::KIND_WAKE |-> out_last)
    else $error("single result without last");

  // Time replies carry no task
  a_time_tid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == swdq_pkg::KIND_TIME |-> out_task_id_res == '0)
    else $error("time reply with task id");

  // A query or delay request leaves the block busy in the cycle after it is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
      (in_req_type == swdq_pkg::REQ_QUERY || in_req_type == swdq_pkg::REQ_DELAY)
      |=> !in_ready)
    else $error("request taken while previous one in progress");

endmodule

bind sorted_wakeup_delay_queue swdq_checker u_swdq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_req_type     (in_ch.req_type),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_task_id_res (out_ch.task_id_res),
  .out_ticks       (out_ch.ticks),
  .out_last        (out_ch.last)
);

@@ verif/sorted_wakeup_delay_queue_test.sv @@
// Self-checking testbench for sorted_wakeup_delay_queue: tick, time query and
// delay requests, with a timer-queue predictor and random idling on both sides.
// Depends on swdq_pkg, the swdq_in_if/swdq_out_if interfaces and the block RTL.
module sorted_wakeup_delay_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swdq_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int DEPTH = QUEUE_DEPTH;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 410;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 24;
  // Wake times at or above this are never reached by the tick count in one run.
  localparam logic [TIME_W-1:0] FAR_TIME = 32'h0100_0000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TID_W-1:0]  tid;
    logic [TIME_W-1:0] ticks;
    logic              last;
  } reply_t;

  typedef struct packed {
    logic [TIME_W-1:0] wake;
    logic [TID_W-1:0]  tid;
  } sleeper_t;

  typedef struct packed {
    logic [1:0]        req;
    logic [TID_W-1:0]  tid;
    logic [TIME_W-1:0] wake;
    logic              has_exp;
    reply_t            exp;
  } dir_row_t;

  // Directed requests; typed replies only where they are obvious.
  localparam int DIR_ROWS = 17;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{REQ_QUERY, 8'h00, 32'h0000_0000, 1'b1, '{KIND_TIME,   8'h00, 32'd0, 1'b1}},
    '{REQ_DELAY, 8'h00, 32'h0000_0000, 1'b1, '{KIND_ACCEPT, 8'h00, 32'd0, 1'b1}},
    '{REQ_TICK,  8'h00, 32'h0000_0000, 1'b0, '0},  // wake time already past
    '{REQ_QUERY, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{KIND_TIME,   8'h00, 32'd1, 1'b1}},
    '{REQ_DELAY, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{KIND_ACCEPT, 8'hFF, 32'd1, 1'b1}},
    '{REQ_DELAY, 8'hA5, 32'd3,         1'b1, '{KIND_ACCEPT, 8'hA5, 32'd1, 1'b1}},
    '{REQ_DELAY, 8'h5A, 32'd3,         1'b1, '{KIND_ACCEPT, 8'h5A, 32'd1, 1'b1}},
    '{REQ_DELAY, 8'h07, 32'd2,         1'b1, '{KIND_ACCEPT, 8'h07, 32'd1, 1'b1}},
    '{REQ_DELAY, 8'h3C, 32'd0,         1'b1, '{KIND_ACCEPT, 8'h3C, 32'd1, 1'b1}},
    '{REQ_TICK,  8'h00, 32'h0000_0000, 1'b0, '0},
    '{REQ_TICK,  8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{REQ_TICK,  8'h00, 32'h0000_0000, 1'b0, '0},  // equal wake times, arrival order
    '{REQ_TICK,  8'h00, 32'h0000_0000, 1'b0, '0},  // nothing due
    '{REQ_QUERY, 8'h00, 32'h0000_0000, 1'b1, '{KIND_TIME,   8'h00, 32'd5, 1'b1}},
    '{REQ_DELAY, 8'h81, 32'd5,         1'b1, '{KIND_ACCEPT, 8'h81, 32'd5, 1'b1}},
    '{REQ_TICK,  8'h00, 32'h0000_0000, 1'b0, '0}
  };

  // Idle and stall odds per random phase, in percent.
  localparam int SEND_IDLE [4] = '{0, 78, 0, 29};
  localparam int RECV_STALL [4] = '{0, 0, 78, 29};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  swdq_in_if  req_ch ();
  swdq_out_if res_ch ();

  sorted_wakeup_delay_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch),
    .out_ch(res_ch)
  );

  // Timer model state
  logic [TIME_W-1:0] model_now = '0;
  sleeper_t sleepers[$];
  reply_t step_replies[$];
  reply_t awaited_replies[$];

  // Typed reply for the request currently offered
  logic   typed_pending = 1'b0;
  reply_t typed_reply = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int error_count = 0;
  int cycle_count = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Advance the timer model by one request; its replies land in step_replies.
  function automatic void predict_timer_step(input logic [1:0] req,
                                             input logic [TID_W-1:0] tid,
                                             input logic [TIME_W-1:0] wake);
    int pos;
    sleeper_t s;
    step_replies.delete();
    case (req)
      REQ_TICK: begin
        model_now = model_now + TIME_W'(1);
        while (sleepers.size() > 0 && sleepers[0].wake < model_now) begin
          step_replies.push_back('{KIND_WAKE, sleepers[0].tid, sleepers[0].wake, 1'b0});
          void'(sleepers.pop_front());
        end
        if (step_replies.size() > 0)
          step_replies[step_replies.size() - 1].last = 1'b1;
      end
      REQ_QUERY: begin
        step_replies.push_back('{KIND_TIME, '0, model_now, 1'b1});
      end
      REQ_DELAY: begin
        if (sleepers.size() >= DEPTH) begin
          step_replies.push_back('{KIND_REJECT, tid, model_now, 1'b1});
        end else begin
          // goes after every entry that wakes at the same time or earlier
          pos = 0;
          while (pos < sleepers.size() && sleepers[pos].wake <= wake)
            pos++;
          s.wake = wake;
          s.tid = tid;
          sleepers.insert(pos, s);
          step_replies.push_back('{KIND_ACCEPT, tid, model_now, 1'b1});
        end
      end
      default: ;
    endcase
  endfunction

  // Receiver: random stalls
  always @(negedge clk) begin
    res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Accepted requests feed the model; accepted replies are checked in order.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        predict_timer_step(req_ch.req_type, req_ch.task_id, req_ch.wake_time);
        if (typed_pending)
          awaited_replies.push_back(typed_reply);
        else
          foreach (step_replies[i]) awaited_replies.push_back(step_replies[i]);
      end
      if (res_ch.valid === 1'b1 && res_ch.ready) begin
        if (awaited_replies.size() == 0) begin
          report_error($sformatf("unexpected reply kind %0d task %0h ticks %0h",
                                 res_ch.kind, res_ch.task_id_res, res_ch.ticks));
        end else begin
          want = awaited_replies.pop_front();
          if (res_ch.kind !== want.kind)
            report_error($sformatf("kind %0d, expected %0d", res_ch.kind, want.kind));
          if (res_ch.task_id_res !== want.tid)
            report_error($sformatf("task_id_res %0h, expected %0h",
                                   res_ch.task_id_res, want.tid));
          if (res_ch.ticks !== want.ticks)
            report_error($sformatf("ticks %0h, expected %0h", res_ch.ticks, want.ticks));
          if (res_ch.last !== want.last)
            report_error($sformatf("last %0b, expected %0b", res_ch.last, want.last));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one request at a falling edge and hold it until accepted.
  task automatic drive_request(input logic [1:0] req, input logic [TID_W-1:0] tid,
                               input logic [TIME_W-1:0] wake, input logic has_exp,
                               input reply_t exp);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.req_type = req;
    req_ch.task_id = tid;
    req_ch.wake_time = wake;
    typed_pending = has_exp;
    typed_reply = exp;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    if (req != REQ_UNUSED)
      items_sent++;
    @(negedge clk);
  endtask

  // Random task id
  function automatic logic [TID_W-1:0] rand_tid();
    return TID_W'($urandom_range(255));
  endfunction

  // Mostly near-future wake times, some already past, rarely one never reached.
  function automatic logic [TIME_W-1:0] pick_wake();
    int far_count;
    int unsigned sel;
    int unsigned back;
    far_count = 0;
    foreach (sleepers[i])
      if (sleepers[i].wake >= FAR_TIME) far_count++;
    sel = $urandom_range(99);
    if (sel < 3 && far_count < 4)
      return $urandom() | FAR_TIME;
    if (sel < 15) begin
      back = $urandom_range(3);
      return (model_now >= back) ? model_now - back : '0;
    end
    return model_now + $urandom_range(30);
  endfunction

  // Fill the queue, overflow it once, query the time, then tick four times to release the entries it added.
  task automatic fill_and_flush();
    while (sleepers.size() < DEPTH)
      drive_request(REQ_DELAY, rand_tid(), model_now + $urandom_range(1, 2),
                    1'b0, '0);
    drive_request(REQ_DELAY, rand_tid(), $urandom(), 1'b0, '0);
    drive_request(REQ_QUERY, rand_tid(), $urandom(), 1'b0, '0);
    repeat (4) drive_request(REQ_TICK, rand_tid(), $urandom(), 1'b0, '0);
  endtask

  initial begin
    int base;
    int phase;
    int last_phase;
    int unsigned pick;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.task_id = '0;
    req_ch.wake_time = '0;
    res_ch.ready = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    for (int row = 0; row < DIR_ROWS; row++)
      drive_request(DIRECTED[row].req, DIRECTED[row].tid, DIRECTED[row].wake,
                    DIRECTED[row].has_exp, DIRECTED[row].exp);

    // Random requests, four idling phases, each opened by a full-queue pass
    base = items_sent;
    last_phase = -1;
    while (items_sent - base < RAND_ITEMS) begin
      phase = (items_sent - base) * 4 / RAND_ITEMS;
      if (phase > 3) phase = 3;
      if (phase != last_phase) begin
        send_idle_pct = SEND_IDLE[phase];
        recv_stall_pct = RECV_STALL[phase];
        last_phase = phase;
        fill_and_flush();
      end
      pick = $urandom_range(99);
      if (pick < 4) begin
        repeat ($urandom_range(8, 36))
          drive_request(REQ_DELAY, rand_tid(), pick_wake(), 1'b0, '0);
      end else if (pick < 7) begin
        repeat ($urandom_range(10, 45))
          drive_request(REQ_TICK, rand_tid(), $urandom(), 1'b0, '0);
      end else if (pick < 11) begin
        drive_request(REQ_UNUSED, rand_tid(), $urandom(), 1'b0, '0);
      end else if (pick < 21) begin
        drive_request(REQ_QUERY, rand_tid(), $urandom(), 1'b0, '0);
      end else if (pick < 58) begin
        drive_request(REQ_DELAY, rand_tid(), pick_wake(), 1'b0, '0);
      end else begin
        drive_request(REQ_TICK, rand_tid(), $urandom(), 1'b0, '0);
      end
    end
    req_ch.valid = 1'b0;

    // Drain, then give a stray reply time to show up
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
